FILE: design/mvt_pkg.sv
`default_nettype none

package mvt_pkg;

	// element and arithmetic widths
	localparam int N_ELEM    = 4;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int FRAC_BITS = 16;

	// configuration register file
	localparam int NUM_REGS = 2 * N_ELEM;
	localparam int REG_W    = 2 * DATA_W;
	localparam int REG_SEL_W = $clog2(NUM_REGS);
	localparam int BYTE_W   = $clog2(REG_W / 8);
	localparam int ADDR_W   = REG_SEL_W + BYTE_W;

	// 1.0 in the coefficient format
	localparam logic [DATA_W-1:0] COEF_ONE = DATA_W'(1) << FRAC_BITS;

	// saturation bounds, sign-extended to the accumulator width
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

	typedef logic [N_ELEM-1:0][DATA_W-1:0] vec_t;
	typedef logic [N_ELEM-1:0][DATA_W-1:0] coef_col_t;
	typedef logic [N_ELEM-1:0][ACC_W-1:0]  acc_vec_t;
	typedef logic [N_ELEM-1:0][PROD_W-1:0] prod_vec_t;
	typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_file_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic      valid;
		vec_t      vec;
		acc_vec_t  acc;
		prod_vec_t prod;
	} mvt_stage_t;

	// result leaving the output stage
	typedef struct packed {
		logic valid;
		vec_t res;
		logic sat;
	} mvt_result_t;

	// identity matrix at reset; row r, column c sits in register 2r + c/2
	function automatic cfg_file_t cfg_reset_value();
		cfg_file_t v;
		v = '0;
		for (int r = 0; r < N_ELEM; r++) begin
			v[2 * r + r / 2][(r % 2) * DATA_W +: DATA_W] = COEF_ONE;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: design/mvt_cell.sv
`default_nettype none

// One column of the matrix: multiplies the column by the vector element at
// the head of the incoming vector and folds the previous cell's products
// into the running row sums.
module mvt_cell
	import mvt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire mvt_stage_t d,
	input  wire coef_col_t  coef,
	output mvt_stage_t      q
);

	function automatic logic [PROD_W-1:0] mul_s(input logic signed [DATA_W-1:0] a,
	                                            input logic signed [DATA_W-1:0] b);
		logic signed [PROD_W-1:0] p;
		p = a * b;
		return p;
	endfunction

	logic       valid_s1;
	vec_t       vec_s1;
	acc_vec_t   acc_s1;
	prod_vec_t  prod_s1;

	vec_t       vec_nxt;
	acc_vec_t   acc_nxt;
	prod_vec_t  prod_nxt;

	// shift the vector toward the head, accumulate, multiply this column
	always_comb begin
		for (int i = 0; i < N_ELEM - 1; i++) begin
			vec_nxt[i] = d.vec[i + 1];
		end
		vec_nxt[N_ELEM-1] = '0;
		for (int r = 0; r < N_ELEM; r++) begin
			acc_nxt[r]  = d.acc[r] + {{(ACC_W - PROD_W){d.prod[r][PROD_W-1]}}, d.prod[r]};
			prod_nxt[r] = mul_s(coef[r], d.vec[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1  <= vec_nxt;
			acc_s1  <= acc_nxt;
			prod_s1 <= prod_nxt;
		end
	end

	assign q.valid = valid_s1;
	assign q.vec   = vec_s1;
	assign q.acc   = acc_s1;
	assign q.prod  = prod_s1;

endmodule

`default_nettype wire

FILE: design/mvt_sat.sv
`default_nettype none

// Final add of the last column, then fixed-point shift and clipping to
// 32 bits. The second stage is the output register.
module mvt_sat
	import mvt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire mvt_stage_t d,
	output mvt_result_t     q
);

	logic     valid_s1;
	acc_vec_t sum_s1;
	logic     valid_s2;
	vec_t     res_s2;
	logic     sat_s2;

	acc_vec_t sum_nxt;
	vec_t     res_nxt;
	logic     sat_nxt;

	// last product into the row sums
	always_comb begin
		for (int r = 0; r < N_ELEM; r++) begin
			sum_nxt[r] = d.acc[r] + {{(ACC_W - PROD_W){d.prod[r][PROD_W-1]}}, d.prod[r]};
		end
	end

	// arithmetic shift (floor) and clip
	always_comb begin
		logic signed [ACC_W-1:0] sh;
		sat_nxt = 1'b0;
		for (int r = 0; r < N_ELEM; r++) begin
			sh = $signed(sum_s1[r]) >>> FRAC_BITS;
			if (sh > SAT_MAX) begin
				res_nxt[r] = SAT_MAX[DATA_W-1:0];
				sat_nxt    = 1'b1;
			end else if (sh < SAT_MIN) begin
				res_nxt[r] = SAT_MIN[DATA_W-1:0];
				sat_nxt    = 1'b1;
			end else begin
				res_nxt[r] = sh[DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_nxt;
			res_s2 <= res_nxt;
			sat_s2 <= sat_nxt;
		end
	end

	assign q.valid = valid_s2;
	assign q.res   = res_s2;
	assign q.sat   = sat_s2;

endmodule

`default_nettype wire

FILE: design/matrix4_vector_transform_unit.sv
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_stall    x_in, y_in, z_in, w_in (signed Q16.16)
// out       out_valid / out_stall  x_out, y_out, z_out, w_out, saturated
// config    APB, 64-bit data       matrix rows, register i at byte 8*i
//
// One item per cycle sustained while no result is held under out_stall; the registers are one per column cell
// (four), then the final add and the shift/clip output register.
// Reset clears the stage valids and loads the identity matrix.
// A result held under out_stall freezes the whole chain and raises in_stall.
module matrix4_vector_transform_unit
	import mvt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [ADDR_W-1:0]        paddr,
	input  wire logic [REG_W-1:0]         pwdata,
	output logic      [REG_W-1:0]         prdata,
	output logic                          pready,

	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [DATA_W-1:0] x_in,
	input  wire logic signed [DATA_W-1:0] y_in,
	input  wire logic signed [DATA_W-1:0] z_in,
	input  wire logic signed [DATA_W-1:0] w_in,

	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      x_out,
	output logic signed [DATA_W-1:0]      y_out,
	output logic signed [DATA_W-1:0]      z_out,
	output logic signed [DATA_W-1:0]      w_out,
	output logic                          saturated
);

	cfg_file_t    cfg_q;
	logic [REG_SEL_W-1:0] reg_sel;
	logic         en;
	mvt_stage_t   chain [N_ELEM+1];
	coef_col_t    coef [N_ELEM];
	mvt_result_t  result;

	// configuration registers
	assign reg_sel = paddr[ADDR_W-1:BYTE_W];
	assign pready  = 1'b1;
	assign prdata  = cfg_q[reg_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cfg_reset_value();
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[reg_sel] <= pwdata;
		end
	end

	// split the registers into matrix columns, one per cell
	always_comb begin
		for (int c = 0; c < N_ELEM; c++) begin
			for (int r = 0; r < N_ELEM; r++) begin
				coef[c][r] = cfg_q[2 * r + c / 2][(c % 2) * DATA_W +: DATA_W];
			end
		end
	end

	// whole chain advances unless a result is held at the output
	assign en       = !(result.valid && out_stall);
	assign in_stall = !en;

	// head of the chain: new vector, empty sums
	assign chain[0].valid = in_valid;
	assign chain[0].vec   = {w_in, z_in, y_in, x_in};
	assign chain[0].acc   = '0;
	assign chain[0].prod  = '0;

	for (genvar c = 0; c < N_ELEM; c++) begin : g_cell
		mvt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[c]),
			.coef   (coef[c]),
			.q      (chain[c+1])
		);
	end

	mvt_sat u_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (chain[N_ELEM]),
		.q      (result)
	);

	assign out_valid = result.valid;
	assign x_out     = result.res[0];
	assign y_out     = result.res[1];
	assign z_out     = result.res[2];
	assign w_out     = result.res[3];
	assign saturated = result.sat;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
	import mvt_pkg::*;

	// one expected result: four dot products and the clip flag
	typedef struct packed {
		vec_t elem;
		logic sat;
	} xform_result_t;

	// one row of the directed table
	typedef struct {
		int            mat;
		vec_t          vec;
		bit            typed;
		xform_result_t res;
	} vec_case_t;

	typedef enum int {VAL_SMALL, VAL_FULL, VAL_EDGE} val_kind_t;
	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_EVERY_THIRD} rx_mode_t;

	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 84;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_REPORTS  = 10;

	localparam logic signed [ACC_W-1:0] ELEM_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] ELEM_MIN = ACC_W'(-64'sd2147483648);

	localparam vec_t VEC_MAX  = {N_ELEM{32'h7FFF_FFFF}};
	localparam vec_t VEC_MIN  = {N_ELEM{32'h8000_0000}};
	localparam vec_t VEC_ZERO = '0;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [REG_W-1:0]         pwdata;
	logic [REG_W-1:0]         prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] x_in;
	logic signed [DATA_W-1:0] y_in;
	logic signed [DATA_W-1:0] z_in;
	logic signed [DATA_W-1:0] w_in;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] x_out;
	logic signed [DATA_W-1:0] y_out;
	logic signed [DATA_W-1:0] z_out;
	logic signed [DATA_W-1:0] w_out;
	logic                     saturated;

	matrix4_vector_transform_unit u_dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .x_in, .y_in, .z_in, .w_in,
		.out_valid, .out_stall, .x_out, .y_out, .z_out, .w_out, .saturated
	);

	cfg_file_t     matrix_regs;
	xform_result_t pending_results[$];
	vec_case_t     dir_cases[$];
	cfg_file_t     dir_mats[5];
	int            fail_count;
	int            burst_left;
	bit            hold_req;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#1_000_000;
		$display("** matrix4_vector_transform_unit: FAILED **");
		$finish;
	end

	// exact row dot products, floor shift, clip to 32 bits
	function automatic xform_result_t transform_vec(cfg_file_t m, vec_t v);
		xform_result_t r;
		logic signed [ACC_W-1:0] acc;
		logic signed [PROD_W-1:0] prod;
		logic signed [DATA_W-1:0] coef;
		logic signed [DATA_W-1:0] elem;
		r.sat = 1'b0;
		for (int row = 0; row < N_ELEM; row++) begin
			acc = '0;
			for (int col = 0; col < N_ELEM; col++) begin
				coef = m[2 * row + col / 2][(col % 2) * DATA_W +: DATA_W];
				elem = v[col];
				prod = coef * elem;
				acc  = acc + prod;
			end
			acc = acc >>> FRAC_BITS;
			if (acc > ELEM_MAX) begin
				r.elem[row] = ELEM_MAX[DATA_W-1:0];
				r.sat = 1'b1;
			end else if (acc < ELEM_MIN) begin
				r.elem[row] = ELEM_MIN[DATA_W-1:0];
				r.sat = 1'b1;
			end else begin
				r.elem[row] = acc[DATA_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] rand_value(val_kind_t k);
		case (k)
			VAL_SMALL: return 32'($urandom_range(0, 32'hF_FFFF)) - 32'h8_0000;
			VAL_FULL:  return $urandom();
			default: begin
				case ($urandom_range(0, 5))
					0:       return 32'h8000_0000;
					1:       return 32'h7FFF_FFFF;
					2:       return 32'h0000_0000;
					3:       return 32'h0001_0000;
					4:       return 32'hFFFF_0000;
					default: return $urandom();
				endcase
			end
		endcase
	endfunction

	// half full-range elements, the rest small or at the edges
	function automatic vec_t rand_vec();
		vec_t v;
		int   pick;
		for (int k = 0; k < N_ELEM; k++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				v[k] = rand_value(VAL_FULL);
			else if (pick < 8)
				v[k] = rand_value(VAL_SMALL);
			else
				v[k] = rand_value(VAL_EDGE);
		end
		return v;
	endfunction

	function automatic cfg_file_t rand_matrix(val_kind_t k);
		cfg_file_t m;
		for (int i = 0; i < NUM_REGS; i++) begin
			m[i][DATA_W-1:0]      = rand_value(k);
			m[i][REG_W-1:DATA_W]  = rand_value(k);
		end
		return m;
	endfunction

	function automatic cfg_file_t uniform_mat(logic [DATA_W-1:0] c);
		return {(2 * NUM_REGS){c}};
	endfunction

	function automatic vec_t mk_vec(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
	                                logic [DATA_W-1:0] z, logic [DATA_W-1:0] w);
		return {w, z, y, x};
	endfunction

	function automatic void add_case(int mat, vec_t v, bit typed, xform_result_t res);
		vec_case_t c;
		c.mat   = mat;
		c.vec   = v;
		c.typed = typed;
		c.res   = res;
		dir_cases.push_back(c);
	endfunction

	// APB write: setup, access, done on the edge with pready high
	task automatic cfg_write(int idx, logic [REG_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 8);
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		matrix_regs[idx] = val;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_matrix(cfg_file_t m);
		for (int i = 0; i < NUM_REGS; i++)
			cfg_write(i, m[i]);
	endtask

	// stop offering, wait for every result, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// bursts of items with random gaps in between
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_vec(vec_t v, bit typed, xform_result_t res);
		@(negedge clk);
		in_valid <= 1'b1;
		x_in     <= v[0];
		y_in     <= v[1];
		z_in     <= v[2];
		w_in     <= v[3];
		do @(posedge clk); while (in_stall);
		pending_results.push_back(typed ? res : transform_vec(matrix_regs, v));
	endtask

	// output check against the oldest expectation
	task automatic check_result();
		xform_result_t got;
		xform_result_t want;
		bit            bad;
		got.elem = {w_out, z_out, y_out, x_out};
		got.sat  = saturated;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("unexpected result x=%h y=%h z=%h w=%h sat=%b",
					x_out, y_out, z_out, w_out, saturated);
		end else begin
			want = pending_results.pop_front();
			bad  = (got.sat !== want.sat);
			for (int k = 0; k < N_ELEM; k++)
				bad |= (got.elem[k] !== want.elem[k]);
			if (bad) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("mismatch: exp %h %h %h %h sat=%b, got %h %h %h %h sat=%b",
						want.elem[0], want.elem[1], want.elem[2], want.elem[3], want.sat,
						got.elem[0], got.elem[1], got.elem[2], got.elem[3], got.sat);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
	end

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       rx_cycle;
		mode      = RX_OPEN;
		mode_left = 0;
		rx_cycle  = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				rx_cycle++;
				case (mode)
					RX_OPEN:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
					RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
					default:  out_stall <= (rx_cycle % 3 == 0);
				endcase
			end
		end
	end

	// stimulus
	initial begin
		vec_t v;
		int   cur_mat;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		x_in       = '0;
		y_in       = '0;
		z_in       = '0;
		w_in       = '0;
		hold_req   = 1'b0;
		burst_left = 0;
		fail_count = 0;

		// matrix after reset is the identity
		matrix_regs    = '0;
		matrix_regs[0] = 64'h0000_0000_0001_0000;
		matrix_regs[2] = 64'h0001_0000_0000_0000;
		matrix_regs[5] = 64'h0000_0000_0001_0000;
		matrix_regs[7] = 64'h0001_0000_0000_0000;

		// directed matrices; the first is the reset identity, never written
		dir_mats[0] = '0;
		dir_mats[1] = uniform_mat(32'h8000_0000);
		dir_mats[2] = uniform_mat(32'h7FFF_FFFF);
		dir_mats[3] = uniform_mat(32'h0000_0001);
		dir_mats[4] = '0;
		dir_mats[4][0] = {32'h7FFF_FFFF, 32'h8000_0000};
		dir_mats[4][1] = {32'hFFFF_0000, 32'h0001_0000};
		dir_mats[4][2] = {32'h0000_8000, 32'hFFFF_FFFF};
		dir_mats[4][3] = {32'h4000_0000, 32'hC000_0000};
		dir_mats[4][5] = {32'h0001_0000, 32'h7FFF_FFFF};
		dir_mats[4][6] = {32'h8000_0000, 32'h8000_0000};
		dir_mats[4][7] = {32'h0000_0003, 32'hFFFF_FFFD};

		// identity passes the vector through
		v = VEC_ZERO;
		add_case(0, v, 1'b1, '{elem: v, sat: 1'b0});
		v = mk_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000);
		add_case(0, v, 1'b1, '{elem: v, sat: 1'b0});
		v = mk_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		add_case(0, v, 1'b1, '{elem: v, sat: 1'b0});
		v = mk_vec(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
		add_case(0, v, 1'b1, '{elem: v, sat: 1'b0});
		// all coefficients at the negative limit: clip both ways, sums wider than 64 bits
		add_case(1, VEC_MAX, 1'b1, '{elem: VEC_MIN, sat: 1'b1});
		add_case(1, VEC_MIN, 1'b1, '{elem: VEC_MAX, sat: 1'b1});
		add_case(1, VEC_ZERO, 1'b1, '{elem: VEC_ZERO, sat: 1'b0});
		add_case(1, mk_vec(32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 1'b0, '0);
		add_case(1, mk_vec(32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0, '0);
		// all coefficients at the positive limit
		add_case(2, VEC_MAX, 1'b1, '{elem: VEC_MAX, sat: 1'b1});
		add_case(2, VEC_MIN, 1'b1, '{elem: VEC_MIN, sat: 1'b1});
		add_case(2, mk_vec(1, 0, 0, 0), 1'b0, '0);
		add_case(2, mk_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
			1'b0, '0);
		// smallest coefficient: the shift floors toward minus infinity
		add_case(3, mk_vec(32'hFFFF_FFFF, 0, 0, 0), 1'b1,
			'{elem: {N_ELEM{32'hFFFF_FFFF}}, sat: 1'b0});
		add_case(3, mk_vec(1, 0, 0, 0), 1'b1, '{elem: VEC_ZERO, sat: 1'b0});
		add_case(3, VEC_MAX, 1'b0, '0);
		add_case(3, VEC_MIN, 1'b0, '0);
		// mixed matrix, some rows clip and some do not
		add_case(4, VEC_MAX, 1'b0, '0);
		add_case(4, VEC_MIN, 1'b0, '0);
		add_case(4, mk_vec(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h1234_5678),
			1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		cur_mat = 0;
		foreach (dir_cases[i]) begin
			if (dir_cases[i].mat != cur_mat) begin
				drain();
				load_matrix(dir_mats[dir_cases[i].mat]);
				cur_mat = dir_cases[i].mat;
			end
			pace();
			send_vec(dir_cases[i].vec, dir_cases[i].typed, dir_cases[i].res);
		end

		// random phases, each with a new matrix
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			load_matrix(rand_matrix(val_kind_t'(p % 3)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 30)
					hold_req = 1'b1;
				pace();
				send_vec(rand_vec(), 1'b0, '0);
			end
		end

		drain();
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("** matrix4_vector_transform_unit: PASSED **");
		end else begin
			$display("** matrix4_vector_transform_unit: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: matrix4_vector_transform_unit.f
design/mvt_pkg.sv
design/mvt_cell.sv
design/mvt_sat.sv
design/matrix4_vector_transform_unit.sv
tb/tb_top.sv
